>>> design/iqii_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the IQ
// interference injector. No dependencies; every other design file imports it.
`default_nettype none

package iqii_pkg;

  // Sample and fixed-point formats.
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned AMP_BITS      = 16;
  localparam int unsigned GAIN_BITS     = AMP_BITS + 2;
  localparam int unsigned PROD_BITS     = GAIN_BITS + SAMPLE_BITS;
  localparam int unsigned SCALE_SHIFT   = 12;
  localparam int          SCALE_ROUND   = 1 << (SCALE_SHIFT - 1);
  localparam int unsigned SUM_BITS      = PROD_BITS - SCALE_SHIFT + 1;
  localparam int unsigned INDEX_BITS    = 32;
  localparam int unsigned PHASE_BITS    = 32;
  localparam int unsigned LCG_BITS      = 32;
  localparam int unsigned KIND_BITS     = 3;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX_W = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN_W = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration port.
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Noise generator constants.
  localparam logic [LCG_BITS-1:0] LCG_MUL    = 32'd1664525;
  localparam logic [LCG_BITS-1:0] LCG_ADD    = 32'd1013904223;
  localparam logic [LCG_BITS-1:0] NOISE_SEED = 32'h0000_BEEF;
  localparam logic [LCG_BITS-1:0] JAM_SEED   = 32'h0000_ABCD;

  // Odd-power polynomial coefficients of the sine, Q30.
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = 64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569305;
  localparam longint SIN_C7 = 64'sd5026995;
  localparam longint SIN_C9 = 64'sd172272;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_KIND        = 3'd0,
    CFG_AMPLITUDE   = 3'd1,
    CFG_WIN_START   = 3'd2,
    CFG_WIN_END     = 3'd3,
    CFG_PHASE_STEP  = 3'd4
  } cfg_idx_e;

  // Interference kinds.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_MATCHED = 3'd0,
    KIND_CW      = 3'd1,
    KIND_NOISE   = 3'd2,
    KIND_JAM     = 3'd3,
    KIND_SPOOF   = 3'd4
  } kind_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic scale;
    logic load_out;
  } dp_cmd_t;

  // Quarter-wave sine entry k of a table with 2^table_bits entries per cycle.
  // Only ever called with constant arguments, so it folds to a constant.
  function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input int unsigned k,
                                                          input int unsigned table_bits);
    longint x;
    longint x2;
    longint p;
    longint s;
    longint r;
    x  = longint'(k) <<< (32 - table_bits);
    x2 = (x * x) >>> 30;
    p  = SIN_C9;
    p  = SIN_C7 - ((x2 * p) >>> 30);
    p  = SIN_C5 - ((x2 * p) >>> 30);
    p  = SIN_C3 - ((x2 * p) >>> 30);
    p  = SIN_C1 - ((x2 * p) >>> 30);
    s  = (x * p) >>> 30;
    r  = (s * longint'(SAMPLE_MAX_W) + (64'sd1 <<< 29)) >>> 30;
    if (r > longint'(SAMPLE_MAX_W)) begin
      r = longint'(SAMPLE_MAX_W);
    end
    if (r < 0) begin
      r = 0;
    end
    return SAMPLE_BITS'(r);
  endfunction

endpackage

`default_nettype wire

>>> design/iqii_ctrl.sv
// Sequencing controller of the IQ interference injector.
// Depends on iqii_pkg for the state type and the datapath command struct.
`default_nettype none

module iqii_ctrl import iqii_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL1:  cmd_o.mul1  = 1'b1;
      ST_MUL2:  cmd_o.mul2  = 1'b1;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_DONE:  cmd_o.load_out = out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Output valid holds until the receiver takes the beat.
  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> design/iqii_datapath.sv
// Datapath of the IQ interference injector: configuration registers, sample
// index, delay line, noise and tone generation, scaling and saturation.
// Depends on iqii_pkg; sequenced by iqii_ctrl through dp_cmd_t.
`default_nettype none

module iqii_datapath import iqii_pkg::*; #(
  parameter int unsigned SPOOF_DELAY     = 5,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dp_cmd_t                         cmd_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]         cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0]        cfg_wdata_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_i_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_q_i,
  input  wire logic                            first_of_buffer_i,
  output logic signed [SAMPLE_BITS-1:0]        out_i_o,
  output logic signed [SAMPLE_BITS-1:0]        out_q_o,
  output logic                                 in_window_o
);

  localparam int unsigned TAB_N     = 1 << SINE_TABLE_BITS;
  localparam int unsigned QN        = TAB_N / 4;
  localparam int unsigned QIDX_BITS = SINE_TABLE_BITS - 1;

  // Configuration registers.
  logic [KIND_BITS-1:0]         kind_q;
  logic signed [AMP_BITS-1:0]   amp_q;
  logic [INDEX_BITS-1:0]        win_start_q;
  logic [INDEX_BITS-1:0]        win_end_q;
  logic [PHASE_BITS-1:0]        phase_step_q;

  // Running state.
  logic [INDEX_BITS-1:0]        index_q;
  logic signed [SAMPLE_BITS-1:0] delay_i_q [SPOOF_DELAY];
  logic signed [SAMPLE_BITS-1:0] delay_q_q [SPOOF_DELAY];

  // Per-item stage registers.
  logic [INDEX_BITS-1:0]         n_q;
  logic signed [SAMPLE_BITS-1:0] x_i_q, x_q_q;
  logic signed [SAMPLE_BITS-1:0] spoof_i_q, spoof_q_q;
  logic [PHASE_BITS-1:0]         phase_acc_q;
  logic [LCG_BITS-1:0]           r1_q, r2_q;
  logic                          applied_q;
  logic signed [SAMPLE_BITS-1:0] cos_q, sin_q;
  logic signed [PROD_BITS-1:0]   prod_i_q, prod_q_q;
  logic signed [SAMPLE_BITS-1:0] out_i_q, out_q_q;
  logic                          in_window_q;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= KIND_MATCHED;
      amp_q        <= '0;
      win_start_q  <= '0;
      win_end_q    <= '1;
      phase_step_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KIND:       kind_q       <= cfg_wdata_i[KIND_BITS-1:0];
        CFG_AMPLITUDE:  amp_q        <= cfg_wdata_i[AMP_BITS-1:0];
        CFG_WIN_START:  win_start_q  <= cfg_wdata_i[INDEX_BITS-1:0];
        CFG_WIN_END:    win_end_q    <= cfg_wdata_i[INDEX_BITS-1:0];
        CFG_PHASE_STEP: phase_step_q <= cfg_wdata_i[PHASE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept: a start-of-buffer mark restarts the index and empties the delay line.
  logic [INDEX_BITS-1:0] n_acc;
  logic                  spoof_ready;

  assign n_acc       = first_of_buffer_i ? '0 : index_q;
  assign spoof_ready = n_acc >= INDEX_BITS'(SPOOF_DELAY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
      for (int k = 0; k < SPOOF_DELAY; k++) begin
        delay_i_q[k] <= '0;
        delay_q_q[k] <= '0;
      end
    end else if (cmd_i.accept) begin
      index_q      <= n_acc + INDEX_BITS'(1);
      delay_i_q[0] <= in_i_i;
      delay_q_q[0] <= in_q_i;
      for (int k = 1; k < SPOOF_DELAY; k++) begin
        delay_i_q[k] <= first_of_buffer_i ? '0 : delay_i_q[k-1];
        delay_q_q[k] <= first_of_buffer_i ? '0 : delay_q_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      n_q       <= n_acc;
      x_i_q     <= in_i_i;
      x_q_q     <= in_q_i;
      spoof_i_q <= spoof_ready ? delay_i_q[SPOOF_DELAY-1] : in_i_i;
      spoof_q_q <= spoof_ready ? delay_q_q[SPOOF_DELAY-1] : in_q_i;
    end
  end

  // First multiply step: tone phase, first noise draw, window test.
  logic [LCG_BITS-1:0]   seed;
  logic [LCG_BITS-1:0]   r1_d;
  logic [PHASE_BITS-1:0] phase_d;
  logic                  applied_d;

  assign seed      = ((kind_q == KIND_JAM) ? JAM_SEED : NOISE_SEED) + n_q;
  assign r1_d      = seed * LCG_MUL + LCG_ADD;
  assign phase_d   = n_q * phase_step_q;
  assign applied_d = (n_q >= win_start_q) && (n_q <= win_end_q) &&
                     (kind_q inside {[KIND_MATCHED:KIND_SPOOF]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
    end else if (cmd_i.mul1) begin
      phase_acc_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      r1_q      <= r1_d;
      applied_q <= applied_d;
    end
  end

  // Quarter-wave sine table, folded to constants at elaboration.
  logic [SAMPLE_BITS-1:0] qsin_tab [QN+1];

  for (genvar g = 0; g <= QN; g++) begin : g_qsin
    assign qsin_tab[g] = quarter_sine(g, SINE_TABLE_BITS);
  end

  // Second multiply step: second noise draw and the sine and cosine lookups.
  logic [LCG_BITS-1:0]           r2_d;
  logic [SINE_TABLE_BITS-1:0]    e_sin, e_cos;
  logic [QIDX_BITS-1:0]          sin_idx, cos_idx;
  logic signed [SAMPLE_BITS-1:0] sin_mag, cos_mag, sin_d, cos_d;

  assign r2_d  = r1_q * LCG_MUL + LCG_ADD;
  assign e_sin = phase_acc_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign e_cos = e_sin + SINE_TABLE_BITS'(QN);

  // Odd quadrants mirror the quarter wave, the upper half negates it.
  assign sin_idx = e_sin[SINE_TABLE_BITS-2]
                 ? QIDX_BITS'(QN) - {1'b0, e_sin[SINE_TABLE_BITS-3:0]}
                 : {1'b0, e_sin[SINE_TABLE_BITS-3:0]};
  assign cos_idx = e_cos[SINE_TABLE_BITS-2]
                 ? QIDX_BITS'(QN) - {1'b0, e_cos[SINE_TABLE_BITS-3:0]}
                 : {1'b0, e_cos[SINE_TABLE_BITS-3:0]};
  assign sin_mag = qsin_tab[sin_idx];
  assign cos_mag = qsin_tab[cos_idx];
  assign sin_d   = e_sin[SINE_TABLE_BITS-1] ? -sin_mag : sin_mag;
  assign cos_d   = e_cos[SINE_TABLE_BITS-1] ? -cos_mag : cos_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      r2_q  <= r2_d;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  // Scale step: pick the interference operand and gain, then multiply.
  logic signed [GAIN_BITS-1:0]   gain_amp, gain_jam, gain_sel;
  logic signed [SAMPLE_BITS-1:0] noise1, noise2, op_i, op_q;
  logic signed [PROD_BITS-1:0]   prod_i_d, prod_q_d;

  assign gain_amp = GAIN_BITS'(amp_q);
  assign gain_jam = (gain_amp <<< 1) + gain_amp;
  // Top LCG bits re-centered around zero: flipping the MSB subtracts half scale.
  assign noise1   = {~r1_q[LCG_BITS-1], r1_q[LCG_BITS-2 -: SAMPLE_BITS-1]};
  assign noise2   = {~r2_q[LCG_BITS-1], r2_q[LCG_BITS-2 -: SAMPLE_BITS-1]};

  always_comb begin
    gain_sel = gain_amp;
    op_i     = '0;
    op_q     = '0;
    if (applied_q) begin
      case (kind_q)
        KIND_MATCHED: begin
          op_i = x_i_q;
          op_q = x_q_q;
        end
        KIND_CW: begin
          op_i = cos_q;
          op_q = sin_q;
        end
        KIND_NOISE: begin
          op_i = noise1;
          op_q = noise2;
        end
        KIND_JAM: begin
          gain_sel = gain_jam;
          op_i     = noise1;
          op_q     = noise1;
        end
        KIND_SPOOF: begin
          op_i = spoof_i_q;
          op_q = spoof_q_q;
        end
        default: begin
          op_i = '0;
          op_q = '0;
        end
      endcase
    end
  end

  assign prod_i_d = gain_sel * op_i;
  assign prod_q_d = gain_sel * op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      prod_i_q <= prod_i_d;
      prod_q_q <= prod_q_d;
    end
  end

  // Final step: round half up, add to the sample, saturate.
  logic signed [PROD_BITS-1:0]   rnd_i, rnd_q;
  logic signed [SUM_BITS-1:0]    sum_i, sum_q;
  logic signed [SAMPLE_BITS-1:0] sat_i, sat_q;

  assign rnd_i = (prod_i_q + PROD_BITS'(SCALE_ROUND)) >>> SCALE_SHIFT;
  assign rnd_q = (prod_q_q + PROD_BITS'(SCALE_ROUND)) >>> SCALE_SHIFT;
  assign sum_i = SUM_BITS'(rnd_i) + SUM_BITS'(x_i_q);
  assign sum_q = SUM_BITS'(rnd_q) + SUM_BITS'(x_q_q);

  // The sum fits when all bits above the sample's sign bit agree with it.
  always_comb begin
    if ((sum_i[SUM_BITS-1:SAMPLE_BITS-1] == '0) ||
        (sum_i[SUM_BITS-1:SAMPLE_BITS-1] == '1)) begin
      sat_i = sum_i[SAMPLE_BITS-1:0];
    end else begin
      sat_i = sum_i[SUM_BITS-1] ? SAMPLE_MIN_W : SAMPLE_MAX_W;
    end
    if ((sum_q[SUM_BITS-1:SAMPLE_BITS-1] == '0) ||
        (sum_q[SUM_BITS-1:SAMPLE_BITS-1] == '1)) begin
      sat_q = sum_q[SAMPLE_BITS-1:0];
    end else begin
      sat_q = sum_q[SUM_BITS-1] ? SAMPLE_MIN_W : SAMPLE_MAX_W;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_i_q     <= sat_i;
      out_q_q     <= sat_q;
      in_window_q <= applied_q;
    end
  end

  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;
  assign in_window_o = in_window_q;

endmodule

`default_nettype wire

>>> design/iq_interference_injector_core.sv
// IQ interference injector top level: controller plus datapath.
// Depends on iqii_pkg, iqii_ctrl and iqii_datapath.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one IQ sample per beat with
//   a first_of_buffer_i mark that restarts the sample index at zero.
//   Output channel: out_valid_o / out_stall_i carry the sample plus the
//   selected interference, saturated, and in_window_o for that sample.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 kind, 1 amplitude, 2 window start, 3 window end, 4 phase step);
//   write only while no sample is in flight.
//   The controller walks each sample through the two multiply steps (phase
//   and chained noise draws), the scaling multiply and the output load, and
//   accepts no new sample until the last one has been loaded for output.
//   A stalled output beat holds; the next sample is still accepted and
//   worked on, and waits in the final step until the output register frees.
//   Reset clears the configuration to its defaults, the sample index, the
//   delay line and the output valid.
`default_nettype none

module iq_interference_injector_core import iqii_pkg::*; #(
  parameter int unsigned SPOOF_DELAY     = 5,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration port.
  input  wire logic                            cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]         cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0]        cfg_wdata_i,
  // Input channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_i_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_q_i,
  input  wire logic                            first_of_buffer_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        out_i_o,
  output logic signed [SAMPLE_BITS-1:0]        out_q_o,
  output logic                                 in_window_o
);

  dp_cmd_t cmd;

  // Sequencer.
  iqii_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  iqii_datapath #(
    .SPOOF_DELAY     (SPOOF_DELAY),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_i_i            (in_i_i),
    .in_q_i            (in_q_i),
    .first_of_buffer_i (first_of_buffer_i),
    .out_i_o           (out_i_o),
    .out_q_o           (out_q_o),
    .in_window_o       (in_window_o)
  );

endmodule

`default_nettype wire

>>> design/iqii_checker.sv
// Port-level checks for iq_interference_injector_core, bound to the top level.
// Depends on iqii_pkg for the port widths.
`default_nettype none

module iqii_checker import iqii_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [SAMPLE_BITS-1:0]   out_i_o,
  input wire logic [SAMPLE_BITS-1:0]   out_q_o,
  input wire logic                     in_window_o
);

  // A stalled output beat stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_i_o) &&
      $stable(out_q_o) && $stable(in_window_o))
  else $error("stalled output beat changed");

  // One sample at a time: the input stalls right after a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
  else $error("input not stalled after an accepted beat");

  // A new result only follows the work on a sample, with the input stalled meanwhile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 1) && $past(in_stall_o, 2) &&
      $past(in_stall_o, 3))
  else $error("result appeared without a sample in work");

  // The input is never stalled while the block is empty of work and output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !$past(!in_stall_o && !in_valid_i))
  else $error("input stalled while idle");

endmodule

bind iq_interference_injector_core iqii_checker u_iqii_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_i_o     (out_i_o),
  .out_q_o     (out_q_o),
  .in_window_o (in_window_o)
);

`default_nettype wire
